@@ hdl/sirot_pkg.sv @@
// ----------------------------------------------------------------------------
// sirot_pkg
// Shared types and constants of the square image rotator.
// ----------------------------------------------------------------------------
package sirot_pkg;

  // default largest image side
  localparam int SideDefault = 64;

  // depth of the queue between front and back
  localparam int QueueDepth = 2;

  // configuration register indexes
  localparam logic CfgMode = 1'b0;
  localparam logic CfgSide = 1'b1;

  localparam int CfgDataW = 7;

  // rotation modes; the unused code behaves as the half turn
  localparam logic [1:0] ModeCw   = 2'd0;
  localparam logic [1:0] ModeCcw  = 2'd1;
  localparam logic [1:0] ModeHalf = 2'd2;

  localparam logic [6:0] SideReset = 7'd64;

  typedef enum logic {
    OP_LOAD,
    OP_REQUEST
  } op_e;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic pixel;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] side;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       pixel;
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } res_t;

endpackage

@@ hdl/sirot_front.sv @@
// ----------------------------------------------------------------------------
// sirot_front
// Accepts commands, tags them as load or request, and queues them.
// ----------------------------------------------------------------------------
module sirot_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           kind_i,
  input  logic           pixel_in_i,
  output logic           busy,
  output sirot_pkg::item_t q_item_o,
  output logic           q_valid_o,
  input  logic           q_pop_i
);
  import sirot_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t            queue_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;
  item_t            item_in;

  assign busy      = (cnt_q == CntW'(QueueDepth));
  assign push      = start && !busy;
  assign q_valid_o = (cnt_q != '0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_item_o  = queue_q[rptr_q];

  always_comb begin
    item_in.op    = kind_i ? OP_REQUEST : OP_LOAD;
    item_in.pixel = pixel_in_i;
  end

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= item_in;
    end
  end

endmodule

@@ hdl/sirot_back.sv @@
// ----------------------------------------------------------------------------
// sirot_back
// Executes queued commands: stores loaded pixels, and for each request
// splits the output index into row and column, maps it to a source pixel
// and reads it from the image memory.
// ----------------------------------------------------------------------------
module sirot_back #(
  parameter int Side = sirot_pkg::SideDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sirot_pkg::cfg_t   cfg_i,
  input  sirot_pkg::item_t  q_item_i,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  output sirot_pkg::res_t   res_o
);
  import sirot_pkg::*;

  localparam int Cells   = Side * Side;
  localparam int AW      = $clog2(Cells);
  localparam int LCW     = $clog2(Cells + 1);
  localparam int QW      = (AW > 7) ? AW : 7;
  localparam int SideCap = (Side > 127) ? 127 : Side;
  localparam int CntW    = $clog2(AW);

  logic mem [Cells];

  state_e           state_q, state_d;
  logic [LCW-1:0]   lc_q, lc_d, ec_q, ec_d;
  logic             ready_q, ready_d;

  logic [AW-1:0]    div_q, div_d;
  logic [6:0]       rem_q, rem_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             fin_q, fin_d;
  logic [6:0]       row_q, row_d, col_q, col_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic             rd_q;

  logic [6:0]       n, nm1, sr, sc;
  logic [13:0]      prod_nn, addr_sum;
  logic [LCW-1:0]   total, total_m1, idx, lc_next;
  logic             fin;
  logic [7:0]       trial;
  logic             qbit;
  logic             mem_we;

  // effective side, clamped to the supported range
  always_comb begin
    if (cfg_i.side < 7'd2) begin
      n = 7'd2;
    end else if (cfg_i.side > 7'(SideCap)) begin
      n = 7'(SideCap);
    end else begin
      n = cfg_i.side;
    end
  end

  assign nm1      = n - 7'd1;
  assign prod_nn  = {7'b0, n} * {7'b0, n};
  assign total    = LCW'(prod_nn);
  assign total_m1 = total - 1'b1;
  assign fin      = (ec_q >= total_m1);
  assign idx      = fin ? total_m1 : ec_q;
  assign lc_next  = lc_q + 1'b1;

  // restoring division step: one quotient bit per cycle
  assign trial = {rem_q, div_q[AW-1]};
  assign qbit  = (trial >= {1'b0, n});

  always_comb begin
    case (cfg_i.mode)
      ModeCw: begin
        sr = nm1 - col_q;
        sc = row_q;
      end
      ModeCcw: begin
        sr = col_q;
        sc = nm1 - row_q;
      end
      default: begin
        sr = nm1 - row_q;
        sc = nm1 - col_q;
      end
    endcase
  end

  assign addr_sum = {7'b0, sr} * {7'b0, n} + {7'b0, sc};

  always_comb begin
    state_d = state_q;
    lc_d    = lc_q;
    ec_d    = ec_q;
    ready_d = ready_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    row_d   = row_q;
    col_d   = col_q;
    addr_d  = addr_q;
    q_pop_o = 1'b0;
    mem_we  = 1'b0;

    case (state_q)
      ST_FETCH: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.op == OP_LOAD) begin
            if (!ready_q) begin
              if (lc_q < total) begin
                mem_we  = 1'b1;
                lc_d    = lc_next;
                ready_d = (lc_next >= total);
              end else begin
                // side shrank below what is already loaded
                ready_d = 1'b1;
              end
            end
          end else if (ready_q) begin
            div_d   = idx[AW-1:0];
            rem_d   = '0;
            quo_d   = '0;
            cnt_d   = CntW'(AW - 1);
            fin_d   = fin;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = qbit ? 7'(trial - {1'b0, n}) : trial[6:0];
        quo_d = {quo_q[QW-2:0], qbit};
        div_d = div_q << 1;
        if (cnt_q == '0) begin
          state_d = ST_ADDR;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_ADDR: begin
        // quotient and remainder are final: latch row/col, then map
        row_d   = quo_q[6:0];
        col_d   = rem_q;
        state_d = ST_READ;
      end
      ST_READ: begin
        addr_d  = AW'(addr_sum);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (fin_q) begin
          lc_d    = '0;
          ec_d    = '0;
          ready_d = 1'b0;
        end else begin
          ec_d = ec_q + 1'b1;
        end
        state_d = ST_FETCH;
      end
      default: begin
        state_d = ST_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FETCH;
      lc_q    <= '0;
      ec_q    <= '0;
      ready_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      lc_q    <= lc_d;
      ec_q    <= ec_d;
      ready_q <= ready_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    fin_q  <= fin_d;
    row_q  <= row_d;
    col_q  <= col_d;
    addr_q <= addr_d;
  end

  // image memory, one write port and one registered read port
  // addr_q settles at the end of ST_READ; rd_q is valid during ST_EMIT
  logic emit_now;
  assign emit_now = (state_q == ST_EMIT);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[lc_q[AW-1:0]] <= q_item_i.pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_d == ST_EMIT) begin
      rd_q <= mem[addr_d];
    end
  end

  always_comb begin
    res_o.valid = emit_now;
    res_o.pixel = rd_q;
    res_o.row   = row_q[5:0];
    res_o.col   = col_q[5:0];
    res_o.last  = fin_q;
  end

endmodule

@@ hdl/square_image_rotator_core.sv @@
// ----------------------------------------------------------------------------
// square_image_rotator_core
// Square binary image rotator: quarter turns either way and half turn.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low, one per cycle into
// a two-entry queue. A load command retires without leaving the fetch state,
// so a frame streams in at one pixel per clock. A request runs through the
// bit-serial split of the output index into row and column, then the source
// address multiply and the image memory read. Each result appears on done_o
// and the result ports for exactly one cycle and is not held; the receiver
// must take it then. No clearing pass runs after reset.
module square_image_rotator_core #(
  parameter int SIDE = sirot_pkg::SideDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       kind_i,
  input  logic       pixel_in_i,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [sirot_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic       done_o,
  output logic       pixel_out_o,
  output logic [5:0] out_row_o,
  output logic [5:0] out_col_o,
  output logic       last_o
);
  import sirot_pkg::*;

  cfg_t  cfg_q;
  item_t q_item;
  logic  q_valid, q_pop;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= ModeCw;
      cfg_q.side <= SideReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode: cfg_q.mode <= cfg_wdata_i[1:0];
        CfgSide: cfg_q.side <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  sirot_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .kind_i     (kind_i),
    .pixel_in_i (pixel_in_i),
    .busy       (busy),
    .q_item_o   (q_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop)
  );

  sirot_back #(
    .Side (SIDE)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_item_i  (q_item),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .res_o     (res)
  );

  assign done_o      = res.valid;
  assign pixel_out_o = res.pixel;
  assign out_row_o   = res.row;
  assign out_col_o   = res.col;
  assign last_o      = res.last;

endmodule
